>>> src/a85_pkg.sv
`default_nettype none

package a85_pkg;

    localparam int CMD_FIFO_DEPTH = 4;

    localparam logic [1:0] KIND_DATA  = 2'd0;
    localparam logic [1:0] KIND_END   = 2'd1;
    localparam logic [1:0] KIND_ERROR = 2'd2;

    localparam logic [7:0] CH_BANG  = 8'h21;
    localparam logic [7:0] CH_U     = 8'h75;
    localparam logic [7:0] CH_Z     = 8'h7A;
    localparam logic [7:0] CH_TILDE = 8'h7E;
    localparam logic [7:0] CH_LT    = 8'h3C;
    localparam logic [7:0] CH_GT    = 8'h3E;

    typedef struct packed {
        logic [7:0] in_byte;
        logic       in_last;
    } in_word_t;

    typedef struct packed {
        logic [7:0] out_char;
        logic [1:0] out_kind;
        logic       out_end;
    } out_word_t;

    typedef enum logic [2:0] {
        OP_NONE,
        OP_BYTES,
        OP_ZBYTES,
        OP_CLOSE,
        OP_ENC
    } op_t;

    // One command per input word that produces output.
    typedef struct packed {
        logic        pre;
        op_t         op;
        logic [31:0] value;
        logic [2:0]  cnt;
        logic [2:0]  ndata;
        logic        post;
        logic        mark;
        logic [1:0]  mark_kind;
    } cmd_t;

    // Fully laid out output sequence of one command.
    typedef struct packed {
        logic [7:0][7:0] chars;
        logic [7:0][1:0] kinds;
        logic [3:0]      count;
    } job_t;

endpackage

`default_nettype wire

>>> src/ascii85_stream_codec_core.sv
// ASCII85 stream codec. Input words carry one byte and a last flag; output words
// carry one character or byte, a kind (data, end of message, error) and an end
// flag on the final output word caused by an input word. cfg_wr_en with
// cfg_wr_data selects decode (0) or encode (1) and drops any message in progress;
// write it only while the block is idle.
// Both channels move a word on a clock edge where valid is high and stall is low.
// Input words that produce no output only pass the front end.
// Within the output sequence of one command, output runs at one word per cycle
// while out_stall is low. The preparation engine works on one command at a time:
// it loads the command, runs a decode multiply for a 'z' or a frame close or the
// divide-by-85 steps of an encode group, and then hands the job to the output
// side, while the front end keeps accepting input words into the queue.
// A command queue sits between front end and output side; when the receiver
// stalls, the output word holds, the queue fills and in_stall then rises.
// Reset returns the block to decode mode with no message in progress.

`default_nettype none

module ascii85_stream_codec_core #(
    parameter int FIFO_DEPTH = a85_pkg::CMD_FIFO_DEPTH
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              cfg_wr_en,
    input  wire logic              cfg_wr_data,
    input  wire logic              in_valid,
    output logic                   in_stall,
    input  wire a85_pkg::in_word_t in_word,
    output logic                   out_valid,
    input  wire logic              out_stall,
    output a85_pkg::out_word_t     out_word
);

    logic          q_full;
    logic          q_push;
    a85_pkg::cmd_t q_push_cmd;
    logic          q_pop;
    a85_pkg::cmd_t q_head;
    logic          q_not_empty;
    logic          job_valid;
    a85_pkg::job_t job;
    logic          job_take;

    a85_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .in_word     (in_word),
        .q_full      (q_full),
        .push        (q_push),
        .push_cmd    (q_push_cmd)
    );

    a85_fifo #(
        .DEPTH (FIFO_DEPTH)
    ) u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_cmd  (q_push_cmd),
        .full      (q_full),
        .pop       (q_pop),
        .head_cmd  (q_head),
        .not_empty (q_not_empty)
    );

    a85_prep u_prep (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (q_not_empty),
        .cmd       (q_head),
        .pop       (q_pop),
        .job_valid (job_valid),
        .job       (job),
        .job_take  (job_take)
    );

    a85_emit u_emit (
        .clk       (clk),
        .rst_n     (rst_n),
        .job_valid (job_valid),
        .job       (job),
        .job_take  (job_take),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_word  (out_word)
    );

endmodule

`default_nettype wire

>>> src/a85_fifo.sv
`default_nettype none

module a85_fifo #(
    parameter int DEPTH = a85_pkg::CMD_FIFO_DEPTH
) (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          push,
    input  wire a85_pkg::cmd_t push_cmd,
    output logic               full,
    input  wire logic          pop,
    output a85_pkg::cmd_t      head_cmd,
    output logic               not_empty
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    a85_pkg::cmd_t    mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_next;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic             do_push;
    logic             do_pop;

    assign full      = (count_reg == CNT_W'(DEPTH));
    assign not_empty = (count_reg != '0);
    assign do_push   = push && !full;
    assign do_pop    = pop && not_empty;
    assign head_cmd  = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule

`default_nettype wire

>>> src/a85_front.sv
`default_nettype none

module a85_front (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              cfg_wr_en,
    input  wire logic              cfg_wr_data,
    input  wire logic              in_valid,
    output logic                   in_stall,
    input  wire a85_pkg::in_word_t in_word,
    input  wire logic              q_full,
    output logic                   push,
    output a85_pkg::cmd_t          push_cmd
);

    typedef enum logic [1:0] {
        PH_HUNT,
        PH_LT,
        PH_IN,
        PH_DONE
    } phase_t;

    phase_t      phase_reg;
    phase_t      phase_next;
    logic [31:0] group_value_reg;
    logic [31:0] group_value_next;
    logic [2:0]  group_count_reg;
    logic [2:0]  group_count_next;
    logic        prefix_sent_reg;
    logic        prefix_sent_next;
    logic        mode_reg;
    logic        mode_next;

    logic          accept;
    logic [7:0]    b;
    logic          last;
    logic [31:0]   dec_value;
    logic [31:0]   enc_value;
    logic [2:0]    enc_count;
    a85_pkg::cmd_t cmd;

    assign in_stall  = q_full;
    assign accept    = in_valid && !q_full;
    assign b         = in_word.in_byte;
    assign last      = in_word.in_last;
    assign dec_value = 32'(group_value_reg * 32'd85) + {24'd0, 8'(b - a85_pkg::CH_BANG)};
    assign enc_value = {group_value_reg[23:0], b};
    assign enc_count = group_count_reg + 3'd1;

    always_comb
    begin
        phase_next       = phase_reg;
        group_value_next = group_value_reg;
        group_count_next = group_count_reg;
        prefix_sent_next = prefix_sent_reg;
        mode_next        = mode_reg;
        cmd              = '0;
        cmd.op           = a85_pkg::OP_NONE;
        cmd.mark_kind    = a85_pkg::KIND_DATA;

        if (accept)
        begin
            if (mode_reg)
            begin
                cmd.pre          = !prefix_sent_reg;
                prefix_sent_next = 1'b1;
                if (enc_count == 3'd4)
                begin
                    cmd.op           = a85_pkg::OP_ENC;
                    cmd.value        = enc_value;
                    cmd.ndata        = 3'd5;
                    group_value_next = '0;
                    group_count_next = '0;
                end
                else
                begin
                    group_value_next = enc_value;
                    group_count_next = enc_count;
                    if (last)
                    begin
                        cmd.op    = a85_pkg::OP_ENC;
                        cmd.ndata = enc_count + 3'd1;
                        case (enc_count)
                            3'd1:    cmd.value = {enc_value[7:0], 24'd0};
                            3'd2:    cmd.value = {enc_value[15:0], 16'd0};
                            default: cmd.value = {enc_value[23:0], 8'd0};
                        endcase
                    end
                end
                cmd.post      = last;
                cmd.mark      = last;
                cmd.mark_kind = a85_pkg::KIND_END;
            end
            else
            begin
                case (phase_reg)
                    PH_HUNT:
                    begin
                        if (b == a85_pkg::CH_LT)
                        begin
                            phase_next = PH_LT;
                        end
                    end
                    PH_LT:
                    begin
                        if (b == a85_pkg::CH_TILDE)
                        begin
                            phase_next = PH_IN;
                        end
                        else if (b != a85_pkg::CH_LT)
                        begin
                            phase_next = PH_HUNT;
                        end
                    end
                    PH_IN:
                    begin
                        if (b == a85_pkg::CH_TILDE)
                        begin
                            // A partial group of two or more digits yields bytes.
                            if (group_count_reg >= 3'd2 && group_count_reg <= 3'd4)
                            begin
                                cmd.op    = a85_pkg::OP_CLOSE;
                                cmd.value = group_value_reg + 32'd1;
                                cmd.cnt   = group_count_reg;
                                cmd.ndata = group_count_reg - 3'd1;
                            end
                            group_value_next = '0;
                            group_count_next = '0;
                            phase_next       = PH_DONE;
                        end
                        else if (b == a85_pkg::CH_Z)
                        begin
                            // Five zero digits finish the open group and leave
                            // as many zero digits behind as were pending.
                            cmd.op           = a85_pkg::OP_ZBYTES;
                            cmd.value        = group_value_reg;
                            cmd.cnt          = group_count_reg;
                            cmd.ndata        = 3'd4;
                            group_value_next = '0;
                        end
                        else if (b >= a85_pkg::CH_BANG && b <= a85_pkg::CH_U)
                        begin
                            if (group_count_reg == 3'd4)
                            begin
                                cmd.op           = a85_pkg::OP_BYTES;
                                cmd.value        = dec_value;
                                cmd.ndata        = 3'd4;
                                group_value_next = '0;
                                group_count_next = '0;
                            end
                            else
                            begin
                                group_value_next = dec_value;
                                group_count_next = group_count_reg + 3'd1;
                            end
                        end
                    end
                    default:
                    begin
                    end
                endcase
                cmd.mark      = last;
                cmd.mark_kind = (phase_next == PH_DONE) ? a85_pkg::KIND_END
                                                        : a85_pkg::KIND_ERROR;
            end

            if (last)
            begin
                phase_next       = PH_HUNT;
                group_value_next = '0;
                group_count_next = '0;
                prefix_sent_next = 1'b0;
            end
        end

        if (cfg_wr_en)
        begin
            mode_next        = cfg_wr_data;
            phase_next       = PH_HUNT;
            group_value_next = '0;
            group_count_next = '0;
            prefix_sent_next = 1'b0;
        end
    end

    assign push     = accept && (cmd.pre || cmd.mark || (cmd.op != a85_pkg::OP_NONE));
    assign push_cmd = cmd;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg       <= PH_HUNT;
            group_value_reg <= '0;
            group_count_reg <= '0;
            prefix_sent_reg <= 1'b0;
            mode_reg        <= 1'b0;
        end
        else
        begin
            phase_reg       <= phase_next;
            group_value_reg <= group_value_next;
            group_count_reg <= group_count_next;
            prefix_sent_reg <= prefix_sent_next;
            mode_reg        <= mode_next;
        end
    end

endmodule

`default_nettype wire

>>> src/a85_prep.sv
`default_nettype none

module a85_prep (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          cmd_valid,
    input  wire a85_pkg::cmd_t cmd,
    output logic               pop,
    output logic               job_valid,
    output a85_pkg::job_t      job,
    input  wire logic          job_take
);

    // floor(v / 85) equals (v * RECIP) >> 38 for every 32-bit v.
    localparam logic [31:0] DIV85_RECIP = 32'hC0C0C0C1;
    localparam int          DIV85_SHIFT = 38;

    typedef enum logic [1:0] {
        S_IDLE,
        S_MUL,
        S_DIV,
        S_DONE
    } state_t;

    function automatic logic [31:0] pow85(input logic [2:0] cnt);
        logic [31:0] p;
        case (cnt)
            3'd1:    p = 32'd52200625;
            3'd2:    p = 32'd614125;
            3'd3:    p = 32'd7225;
            3'd4:    p = 32'd85;
            default: p = 32'd0;
        endcase
        return p;
    endfunction

    function automatic logic [9:0] slot_word(
        input logic [3:0]      pos,
        input logic [3:0]      lp,
        input logic [3:0]      ld,
        input logic [3:0]      lq,
        input logic [7:0][7:0] data,
        input logic [1:0]      mkind
    );
        logic [3:0] off_d;
        logic [3:0] off_q;
        logic [9:0] w;
        off_d = pos - lp;
        off_q = pos - lp - ld;
        if (pos < lp)
        begin
            w = {(pos == 4'd0) ? a85_pkg::CH_LT : a85_pkg::CH_TILDE, a85_pkg::KIND_DATA};
        end
        else if (pos < lp + ld)
        begin
            w = {data[off_d[2:0]], a85_pkg::KIND_DATA};
        end
        else if (pos < lp + ld + lq)
        begin
            w = {(off_q == 4'd0) ? a85_pkg::CH_TILDE : a85_pkg::CH_GT, a85_pkg::KIND_DATA};
        end
        else
        begin
            w = {8'd0, mkind};
        end
        return w;
    endfunction

    state_t          state_reg;
    state_t          state_next;
    a85_pkg::cmd_t   work_reg;
    a85_pkg::cmd_t   work_next;
    logic [4:0][6:0] digit_reg;
    logic [4:0][6:0] digit_next;
    logic [2:0]      step_reg;
    logic [2:0]      step_next;
    a85_pkg::job_t   job_reg;
    a85_pkg::job_t   job_next;
    logic            job_valid_reg;
    logic            job_valid_next;

    logic [63:0]     div_prod;
    logic [25:0]     div_q;
    logic [6:0]      div_r;
    logic [31:0]     dval;
    logic [7:0][7:0] data;
    logic [3:0]      len_pre;
    logic [3:0]      len_data;
    logic [3:0]      len_post;
    a85_pkg::job_t   built;

    assign div_prod = {32'd0, work_reg.value} * {32'd0, DIV85_RECIP};
    assign div_q    = div_prod[63:DIV85_SHIFT];
    assign div_r    = work_reg.value[6:0] - 7'(div_q[6:0] * 7'd85);

    assign dval     = (work_reg.op == a85_pkg::OP_CLOSE) ? work_reg.value - 32'd1
                                                         : work_reg.value;
    assign len_pre  = work_reg.pre ? 4'd2 : 4'd0;
    assign len_data = {1'b0, work_reg.ndata};
    assign len_post = work_reg.post ? 4'd2 : 4'd0;

    always_comb
    begin
        data = '0;
        if (work_reg.op == a85_pkg::OP_ENC)
        begin
            data[0] = {1'b0, digit_reg[0]} + a85_pkg::CH_BANG;
            data[1] = {1'b0, digit_reg[1]} + a85_pkg::CH_BANG;
            data[2] = {1'b0, digit_reg[2]} + a85_pkg::CH_BANG;
            data[3] = {1'b0, digit_reg[3]} + a85_pkg::CH_BANG;
            data[4] = {1'b0, digit_reg[4]} + a85_pkg::CH_BANG;
        end
        else
        begin
            data[0] = dval[31:24];
            data[1] = dval[23:16];
            data[2] = dval[15:8];
            data[3] = dval[7:0];
        end
    end

    for (genvar k = 0; k < 8; k++)
    begin : g_slot
        assign {built.chars[k], built.kinds[k]} =
            slot_word(4'(k), len_pre, len_data, len_post, data, work_reg.mark_kind);
    end

    assign built.count = len_pre + len_data + len_post + {3'd0, work_reg.mark};

    assign pop       = (state_reg == S_IDLE) && cmd_valid;
    assign job_valid = job_valid_reg;
    assign job       = job_reg;

    always_comb
    begin
        state_next     = state_reg;
        work_next      = work_reg;
        digit_next     = digit_reg;
        step_next      = step_reg;
        job_next       = job_reg;
        job_valid_next = job_valid_reg && !job_take;

        case (state_reg)
            S_IDLE:
            begin
                if (cmd_valid)
                begin
                    work_next = cmd;
                    step_next = '0;
                    if (cmd.op == a85_pkg::OP_ZBYTES || cmd.op == a85_pkg::OP_CLOSE)
                    begin
                        state_next = S_MUL;
                    end
                    else if (cmd.op == a85_pkg::OP_ENC)
                    begin
                        state_next = S_DIV;
                    end
                    else
                    begin
                        state_next = S_DONE;
                    end
                end
            end
            S_MUL:
            begin
                work_next.value = 32'(work_reg.value * pow85(work_reg.cnt));
                state_next      = S_DONE;
            end
            S_DIV:
            begin
                // Digits come out least significant first.
                digit_next[3'd4 - step_reg] = div_r;
                work_next.value             = {6'd0, div_q};
                step_next                   = step_reg + 3'd1;
                if (step_reg == 3'd4)
                begin
                    state_next = S_DONE;
                end
            end
            S_DONE:
            begin
                if (!job_valid_reg || job_take)
                begin
                    job_next       = built;
                    job_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            work_reg      <= '0;
            digit_reg     <= '0;
            step_reg      <= '0;
            job_reg       <= '0;
            job_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            work_reg      <= work_next;
            digit_reg     <= digit_next;
            step_reg      <= step_next;
            job_reg       <= job_next;
            job_valid_reg <= job_valid_next;
        end
    end

endmodule

`default_nettype wire

>>> src/a85_emit.sv
`default_nettype none

module a85_emit (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          job_valid,
    input  wire a85_pkg::job_t job,
    output logic               job_take,
    output logic               out_valid,
    input  wire logic          out_stall,
    output a85_pkg::out_word_t out_word
);

    a85_pkg::job_t buf_reg;
    a85_pkg::job_t buf_next;
    logic [2:0]    idx_reg;
    logic [2:0]    idx_next;
    logic          busy_reg;
    logic          busy_next;
    logic          last_word;
    logic          fire;

    assign last_word         = ({1'b0, idx_reg} == buf_reg.count - 4'd1);
    assign fire              = busy_reg && !out_stall;
    assign job_take          = job_valid && (!busy_reg || (fire && last_word));
    assign out_valid         = busy_reg;
    assign out_word.out_char = buf_reg.chars[idx_reg];
    assign out_word.out_kind = buf_reg.kinds[idx_reg];
    assign out_word.out_end  = last_word;

    always_comb
    begin
        buf_next  = buf_reg;
        idx_next  = idx_reg;
        busy_next = busy_reg;
        if (job_take)
        begin
            buf_next  = job;
            idx_next  = '0;
            busy_next = 1'b1;
        end
        else if (fire)
        begin
            if (last_word)
            begin
                busy_next = 1'b0;
            end
            else
            begin
                idx_next = idx_reg + 3'd1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            buf_reg  <= '0;
            idx_reg  <= '0;
            busy_reg <= 1'b0;
        end
        else
        begin
            buf_reg  <= buf_next;
            idx_reg  <= idx_next;
            busy_reg <= busy_next;
        end
    end

endmodule

`default_nettype wire
